// ===== sv/gdec_pkg.sv =====
package gdec_pkg;

  localparam int unsigned WORD_W    = 20;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned ERPM_W    = 26;
  localparam int unsigned DEN_W     = 16;
  localparam int unsigned MANT_W    = 9;
  localparam int unsigned EXP_W     = 3;
  localparam int unsigned PFIELD_W  = 12;
  localparam int unsigned DIV_STAGES = ERPM_W;

  localparam logic [ERPM_W-1:0]   ERPM_NUMERATOR = ERPM_W'(60000000);
  localparam logic [PFIELD_W-1:0] PERIOD_STOPPED = 12'hFFF;
  localparam logic [NIB_W-1:0]    FOLD_GOOD      = 4'hF;

  // GCR codes of the 16-symbol alphabet.
  localparam logic [CODE_W-1:0] GCR_0 = 5'h19;
  localparam logic [CODE_W-1:0] GCR_1 = 5'h1B;
  localparam logic [CODE_W-1:0] GCR_2 = 5'h12;
  localparam logic [CODE_W-1:0] GCR_3 = 5'h13;
  localparam logic [CODE_W-1:0] GCR_4 = 5'h1D;
  localparam logic [CODE_W-1:0] GCR_5 = 5'h15;
  localparam logic [CODE_W-1:0] GCR_6 = 5'h16;
  localparam logic [CODE_W-1:0] GCR_7 = 5'h17;
  localparam logic [CODE_W-1:0] GCR_8 = 5'h1A;
  localparam logic [CODE_W-1:0] GCR_9 = 5'h09;
  localparam logic [CODE_W-1:0] GCR_A = 5'h0A;
  localparam logic [CODE_W-1:0] GCR_B = 5'h0B;
  localparam logic [CODE_W-1:0] GCR_C = 5'h1E;
  localparam logic [CODE_W-1:0] GCR_D = 5'h0D;
  localparam logic [CODE_W-1:0] GCR_E = 5'h0E;
  localparam logic [CODE_W-1:0] GCR_F = 5'h0F;

  typedef struct packed {
    logic             bad;
    logic [NIB_W-1:0] nib;
  } gcr_sym_t;

  // Request into the divider: quotient of num by den, zero forces a 0 result.
  typedef struct packed {
    logic [ERPM_W-1:0] num;
    logic [DEN_W-1:0]  den;
    logic              zero;
  } div_req_t;

  // Working state of one divider stage: partial remainder, and a word that
  // shifts numerator bits out at the top while quotient bits enter below.
  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [ERPM_W-1:0] nq;
    logic [DEN_W-1:0]  den;
    logic              zero;
  } div_stage_t;

  typedef struct packed {
    logic [ERPM_W-1:0] quot;
    logic              zero;
  } div_rsp_t;

  function automatic gcr_sym_t gcr_decode(input logic [CODE_W-1:0] code);
    gcr_sym_t s;
    s.bad = 1'b0;
    unique case (code)
      GCR_0:   s.nib = 4'h0;
      GCR_1:   s.nib = 4'h1;
      GCR_2:   s.nib = 4'h2;
      GCR_3:   s.nib = 4'h3;
      GCR_4:   s.nib = 4'h4;
      GCR_5:   s.nib = 4'h5;
      GCR_6:   s.nib = 4'h6;
      GCR_7:   s.nib = 4'h7;
      GCR_8:   s.nib = 4'h8;
      GCR_9:   s.nib = 4'h9;
      GCR_A:   s.nib = 4'hA;
      GCR_B:   s.nib = 4'hB;
      GCR_C:   s.nib = 4'hC;
      GCR_D:   s.nib = 4'hD;
      GCR_E:   s.nib = 4'hE;
      GCR_F:   s.nib = 4'hF;
      default: begin
        s.nib = 4'h0;
        s.bad = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

// ===== sv/gcr_erpm_telemetry_decoder.sv =====
// Decoder for the eRPM telemetry reply of a bidirectional motor controller.
// Input channel s_*: each beat carries one 20-bit GCR word in s_tdata[19:0].
// Output channel m_*: each beat carries the electrical RPM in m_tdata[25:0]
// and an error flag in m_tuser[0]. Every input beat yields exactly one output
// beat, in order. The word is split into four GCR codes, mapped to nibbles,
// checksum-checked, and its period field is turned into a divisor; a
// 26-stage restoring divider then forms 60,000,000 / period rounded to
// nearest. A stopped motor gives 0 with no error; an invalid code, a bad
// checksum or a zero mantissa gives 0 with the error flag set.
// From the accepting edge to m_tvalid lie two decode stages, one divider
// stage per quotient bit, and the output register. Throughput is one beat
// per cycle while the skid register is empty, set by the divider producing
// one quotient bit per stage with all stages working on different words.
// When the receiver stalls, one result parks in a skid register behind the
// output register; only once that is full does the pipeline hold and
// s_tready drop, so nothing is lost or repeated. Reset empties all stages.
module gcr_erpm_telemetry_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] gcr_word, [23:20] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [25:0] erpm, [31:26] zero
  output logic [0:0]  m_tuser    // [0] error
);

  localparam int unsigned CW = gdec_pkg::CODE_W;
  localparam int unsigned NW = gdec_pkg::NIB_W;
  localparam int unsigned EW = gdec_pkg::ERPM_W;
  localparam int unsigned DW = gdec_pkg::DEN_W;

  // The whole pipeline moves only while the skid register is empty.
  logic en;

  // Stage 1: GCR decode and checks.
  logic                           d1_vld;
  logic [gdec_pkg::PFIELD_W-1:0]  d1_pfield;
  logic                           d1_err;
  logic                           d1_stop;
  gdec_pkg::gcr_sym_t             sym [4];
  logic [gdec_pkg::PFIELD_W-1:0]  pfield_next;
  logic                           err_next;
  logic                           stop_next;
  logic [NW-1:0]                  fold;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sym[k] = gdec_pkg::gcr_decode(s_tdata[k*CW +: CW]);
    end
    fold        = sym[3].nib ^ sym[2].nib ^ sym[1].nib ^ sym[0].nib;
    pfield_next = {sym[3].nib, sym[2].nib, sym[1].nib};
    // A bad code or checksum wins over every other case.
    err_next    = sym[3].bad | sym[2].bad | sym[1].bad | sym[0].bad |
                  (fold != gdec_pkg::FOLD_GOOD);
    stop_next   = (pfield_next == gdec_pkg::PERIOD_STOPPED);
  end

  // Stage 2: period = mantissa << exponent, numerator gets half a period added.
  logic                 d2_vld;
  gdec_pkg::div_req_t   d2_req;
  gdec_pkg::div_req_t   req_next;
  logic [gdec_pkg::MANT_W-1:0] mant;
  logic [gdec_pkg::EXP_W-1:0]  expo;
  logic [DW-1:0]               period;

  always_comb begin
    mant   = d1_pfield[gdec_pkg::MANT_W-1:0];
    expo   = d1_pfield[gdec_pkg::PFIELD_W-1 -: gdec_pkg::EXP_W];
    period = DW'(mant) << expo;
    req_next.zero = d1_err | d1_stop | (mant == '0);
    // A forced-zero item still needs a nonzero divisor to keep the math tidy.
    req_next.den  = req_next.zero ? DW'(1) : period;
    req_next.num  = gdec_pkg::ERPM_NUMERATOR + EW'(period >> 1);
  end

  logic d2_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
      d2_vld <= 1'b0;
    end else if (en) begin
      d1_vld <= s_tvalid;
      d2_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_pfield <= pfield_next;
      d1_err    <= err_next;
      d1_stop   <= stop_next;
      d2_req    <= req_next;
      d2_err    <= d1_err | (!d1_stop && (mant == '0));
    end
  end

  // The error flag rides alongside the divider in a matching delay line.
  logic                 err_line [gdec_pkg::DIV_STAGES];
  logic                 q_vld;
  gdec_pkg::div_rsp_t   q_rsp;

  always_ff @(posedge clk) begin
    if (en) begin
      err_line[0] <= d2_err;
      for (int k = 1; k < gdec_pkg::DIV_STAGES; k++) begin
        err_line[k] <= err_line[k-1];
      end
    end
  end

  gdec_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d2_vld),
    .req     (d2_req),
    .out_vld (q_vld),
    .rsp     (q_rsp)
  );

  logic [EW-1:0] res_erpm;
  logic          res_err;

  assign res_erpm = q_rsp.zero ? '0 : q_rsp.quot;
  assign res_err  = err_line[gdec_pkg::DIV_STAGES-1];

  // Output register with one skid entry behind it.
  logic          out_vld;
  logic [EW-1:0] out_erpm;
  logic          out_err;
  logic          skid_vld;
  logic [EW-1:0] skid_erpm;
  logic          skid_err;

  assign en = !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld  <= q_vld;
      end
    end else if (q_vld) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_erpm <= skid_erpm;
        out_err  <= skid_err;
      end else begin
        out_erpm <= res_erpm;
        out_err  <= res_err;
      end
    end else if (en) begin
      skid_erpm <= res_erpm;
      skid_err  <= res_err;
    end
  end

  assign s_tready = en;
  assign m_tvalid = out_vld;
  assign m_tdata  = {6'b0, out_erpm};
  assign m_tuser  = out_err;

  // An error result always reports zero speed.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("error beat with nonzero erpm");

  // The skid entry is only used behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid filled while output empty");

  // A parked result stays parked until the output drains.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !m_tready |=> skid_vld && $stable(skid_erpm))
    else $error("skid entry lost during stall");

  // Speed never exceeds the numerator.
  a_erpm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:0] <= gdec_pkg::ERPM_NUMERATOR)
    else $error("erpm out of range");

endmodule

// ===== sv/gdec_divider.sv =====
// Restoring divider, one quotient bit per stage, all stages advance on en.
module gdec_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  gdec_pkg::div_req_t   req,
  output logic                 out_vld,
  output gdec_pkg::div_rsp_t   rsp
);

  localparam int unsigned N = gdec_pkg::DIV_STAGES;
  localparam int unsigned DW = gdec_pkg::DEN_W;
  localparam int unsigned QW = gdec_pkg::ERPM_W;

  logic                 vld [N];
  gdec_pkg::div_stage_t stg [N];
  gdec_pkg::div_stage_t src [N];
  gdec_pkg::div_stage_t stg_next [N];

  always_comb begin
    src[0].rem  = '0;
    src[0].nq   = req.num;
    src[0].den  = req.den;
    src[0].zero = req.zero;
    for (int k = 1; k < N; k++) begin
      src[k] = stg[k-1];
    end
  end

  // Each stage brings down the next numerator bit and tries one subtract.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [DW:0] trial;
      logic        take;
      trial = {src[k].rem, src[k].nq[QW-1]};
      take  = (trial >= {1'b0, src[k].den});
      stg_next[k].rem  = take ? DW'(trial - {1'b0, src[k].den}) : trial[DW-1:0];
      stg_next[k].nq   = {src[k].nq[QW-2:0], take};
      stg_next[k].den  = src[k].den;
      stg_next[k].zero = src[k].zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_vld;
      for (int k = 1; k < N; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign rsp.quot = stg[N-1].nq;
  assign rsp.zero = stg[N-1].zero;

endmodule

// ===== sim/gcr_erpm_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the telemetry decoder, works out the expected
// eRPM and error flag for every accepted GCR word, and compares each
// output beat against the oldest outstanding prediction.
module gcr_erpm_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] gcr_word, [23:20] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [25:0] erpm, [31:26] zero
  input  logic [0:0]  m_tuser,   // [0] error
  output int          fails,
  output int          waiting,
  output int          checked,
  output int          flagged,
  output int          stopped
);

  typedef struct packed {
    logic [gdec_pkg::ERPM_W-1:0] erpm;
    logic                        err;
  } telem_t;

  telem_t telem_due[$];
  telem_t due_now;
  telem_t seen;

  // Maps one GCR code to its nibble; bad is raised for codes outside
  // the alphabet.
  function automatic logic [gdec_pkg::NIB_W:0] code_to_nibble(
    input logic [gdec_pkg::CODE_W-1:0] code
  );
    case (code)
      gdec_pkg::GCR_0: return {1'b0, 4'h0};
      gdec_pkg::GCR_1: return {1'b0, 4'h1};
      gdec_pkg::GCR_2: return {1'b0, 4'h2};
      gdec_pkg::GCR_3: return {1'b0, 4'h3};
      gdec_pkg::GCR_4: return {1'b0, 4'h4};
      gdec_pkg::GCR_5: return {1'b0, 4'h5};
      gdec_pkg::GCR_6: return {1'b0, 4'h6};
      gdec_pkg::GCR_7: return {1'b0, 4'h7};
      gdec_pkg::GCR_8: return {1'b0, 4'h8};
      gdec_pkg::GCR_9: return {1'b0, 4'h9};
      gdec_pkg::GCR_A: return {1'b0, 4'hA};
      gdec_pkg::GCR_B: return {1'b0, 4'hB};
      gdec_pkg::GCR_C: return {1'b0, 4'hC};
      gdec_pkg::GCR_D: return {1'b0, 4'hD};
      gdec_pkg::GCR_E: return {1'b0, 4'hE};
      gdec_pkg::GCR_F: return {1'b0, 4'hF};
      default:         return {1'b1, 4'h0};
    endcase
  endfunction

  // Expected result of one telemetry word.
  function automatic telem_t decode_telemetry(input logic [gdec_pkg::WORD_W-1:0] word);
    telem_t                        r;
    logic [15:0]                   value;
    logic [gdec_pkg::NIB_W:0]      sym;
    logic [gdec_pkg::NIB_W-1:0]    fold;
    logic [gdec_pkg::PFIELD_W-1:0] pfield;
    logic [31:0]                   period;
    r = '0;
    value = '0;
    for (int k = 3; k >= 0; k--) begin
      sym = code_to_nibble(word[k*gdec_pkg::CODE_W +: gdec_pkg::CODE_W]);
      if (sym[gdec_pkg::NIB_W]) begin
        r.err = 1'b1;
        return r;
      end
      value = {value[11:0], sym[gdec_pkg::NIB_W-1:0]};
    end
    fold = value[15:12] ^ value[11:8] ^ value[7:4] ^ value[3:0];
    if (fold != gdec_pkg::FOLD_GOOD) begin
      r.err = 1'b1;
      return r;
    end
    pfield = value[15:4];
    if (pfield == gdec_pkg::PERIOD_STOPPED) return r;
    period = 32'(pfield[gdec_pkg::MANT_W-1:0]) <<
             pfield[gdec_pkg::PFIELD_W-1 -: gdec_pkg::EXP_W];
    if (period == 0) begin
      r.err = 1'b1;
      return r;
    end
    r.erpm = gdec_pkg::ERPM_W'((32'd60000000 + period / 2) / period);
    return r;
  endfunction

  assign waiting = telem_due.size();

  // Outputs are checked before the new input is queued, so a result that
  // appears in the same cycle as its own input could never be masked.
  always @(posedge clk) begin
    if (rst) begin
      telem_due.delete();
      fails   <= 0;
      checked <= 0;
      flagged <= 0;
      stopped <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.erpm = m_tdata[gdec_pkg::ERPM_W-1:0];
        seen.err  = m_tuser[0];
        if (telem_due.size() == 0) begin
          if (fails < 10)
            $display("[%0t] unexpected result beat: erpm=%0d err=%0b",
                     $realtime, seen.erpm, seen.err);
          fails <= fails + 1;
        end else begin
          due_now = telem_due.pop_front();
          if (due_now.erpm !== seen.erpm || due_now.err !== seen.err) begin
            if (fails < 10)
              $display("[%0t] result mismatch: expected erpm=%0d err=%0b, got erpm=%0d err=%0b",
                       $realtime, due_now.erpm, due_now.err, seen.erpm, seen.err);
            fails <= fails + 1;
          end
          checked <= checked + 1;
          if (due_now.err) flagged <= flagged + 1;
          else if (due_now.erpm == 0) stopped <= stopped + 1;
        end
      end
      if (s_tvalid && s_tready)
        telem_due.push_back(decode_telemetry(s_tdata[gdec_pkg::WORD_W-1:0]));
    end
  end

endmodule

// ===== sim/gcr_erpm_telemetry_decoder_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the eRPM telemetry decoder. Prediction and
// comparison live in the checker instance beside the block.
module gcr_erpm_telemetry_decoder_tb;

  localparam int RAND_WORDS  = 800;
  localparam int CALM_WORDS  = 100;    // final stretch sent with no idling
  localparam int HOLD_AT     = 300;    // beats sent before the long stall
  localparam int HOLD_CYCLES = 250;
  localparam int TAIL_CYCLES = 40;     // margin after the last result is checked
  localparam int CYCLE_LIMIT = 200000;

  // Code of each nibble, indexed by nibble value.
  localparam logic [gdec_pkg::CODE_W-1:0] CODE_OF [16] = '{
    gdec_pkg::GCR_0, gdec_pkg::GCR_1, gdec_pkg::GCR_2, gdec_pkg::GCR_3,
    gdec_pkg::GCR_4, gdec_pkg::GCR_5, gdec_pkg::GCR_6, gdec_pkg::GCR_7,
    gdec_pkg::GCR_8, gdec_pkg::GCR_9, gdec_pkg::GCR_A, gdec_pkg::GCR_B,
    gdec_pkg::GCR_C, gdec_pkg::GCR_D, gdec_pkg::GCR_E, gdec_pkg::GCR_F
  };
  localparam logic [gdec_pkg::CODE_W-1:0] BAD_CODE_LO = 5'h00;
  localparam logic [gdec_pkg::CODE_W-1:0] BAD_CODE_HI = 5'h1F;
  localparam logic [gdec_pkg::CODE_W-1:0] BAD_CODE_MID = 5'h1C;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [19:0] gcr_word, [23:20] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [25:0] erpm, [31:26] zero
  logic [0:0]  m_tuser;   // [0] error

  int  fails;
  int  waiting;
  int  checked;
  int  flagged;
  int  stopped;
  int  sent;
  int  cycles = 0;
  bit  calm;      // no idling on either side once set
  bit  holding;   // receiver is in its long stall

  gcr_erpm_telemetry_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  gcr_erpm_check i_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .fails    (fails),
    .waiting  (waiting),
    .checked  (checked),
    .flagged  (flagged),
    .stopped  (stopped)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case the block hangs on either channel.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, waiting);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Turns a 16-bit value into its GCR word, top nibble in the top code.
  function automatic logic [gdec_pkg::WORD_W-1:0] gcr_encode(input logic [15:0] v);
    return {CODE_OF[v[15:12]], CODE_OF[v[11:8]], CODE_OF[v[7:4]], CODE_OF[v[3:0]]};
  endfunction

  // Appends the checksum nibble that makes all four nibbles fold to 0xF.
  function automatic logic [15:0] sealed(input logic [gdec_pkg::PFIELD_W-1:0] pfield);
    return {pfield, ~(pfield[11:8] ^ pfield[7:4] ^ pfield[3:0])};
  endfunction

  // Offers one beat, after an optional idle burst, and returns once it has
  // been accepted. Only one assignment to s_tvalid falls in any time step.
  task automatic send_word(input logic [gdec_pkg::WORD_W-1:0] word);
    if (!calm && !holding && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, word};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Receiver: random stalls, one long stall once the pipeline has some
  // traffic so that the skid register fills and s_tready drops, and steady
  // acceptance for the final stretch.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    holding   = 1'b0;
    @(negedge rst);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (!hold_done && sent >= HOLD_AT) begin
        holding = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        hold_done = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [gdec_pkg::WORD_W-1:0]   word;
    logic [gdec_pkg::PFIELD_W-1:0] pfield;
    logic [15:0]                   value;
    int                            pick;
    int                            slot;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    sent     = 0;
    calm     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: stopped motor, zero period at both exponent ends,
    // the largest and smallest periods, an exact half on rounding, every
    // nibble of the alphabet, bad checksums, and invalid codes in each slot.
    send_word(gcr_encode(sealed(gdec_pkg::PERIOD_STOPPED)));
    send_word(gcr_encode(sealed({3'd0, 9'd0})));
    send_word(gcr_encode(sealed({3'd7, 9'd0})));
    send_word(gcr_encode(sealed({3'd0, 9'd1})));
    send_word(gcr_encode(sealed({3'd7, 9'd511})));
    send_word(gcr_encode(sealed({3'd0, 9'd511})));
    send_word(gcr_encode(sealed({3'd7, 9'd1})));
    send_word(gcr_encode(sealed({3'd1, 9'd256})));
    send_word(gcr_encode(sealed({3'd0, 9'd256})));
    send_word(gcr_encode(sealed(12'h123)));
    send_word(gcr_encode(sealed(12'h456)));
    send_word(gcr_encode(sealed(12'h789)));
    send_word(gcr_encode(sealed(12'hABC)));
    send_word(gcr_encode(sealed(12'hDE0)));
    send_word(gcr_encode(sealed(12'h345) ^ 16'h0001));
    send_word(gcr_encode(sealed(12'hFFF) ^ 16'h0010));
    send_word(20'h00000);
    send_word(20'hFFFFF);
    for (int k = 0; k < 4; k++) begin
      word = gcr_encode(sealed(12'h2A7));
      word[k*gdec_pkg::CODE_W +: gdec_pkg::CODE_W] = (k == 3) ? BAD_CODE_HI :
                                                     (k == 2) ? BAD_CODE_MID : BAD_CODE_LO;
      send_word(word);
    end

    // Random words. Most are well formed so that they reach the divider;
    // the rest exercise the stopped and zero-period cases, corrupted
    // checksums and raw noise across all 20 bits.
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i >= RAND_WORDS - CALM_WORDS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      pfield = gdec_pkg::PFIELD_W'($urandom);
      if (pick < 60) begin
        value = sealed(pfield);
      end else if (pick < 65) begin
        value = sealed(gdec_pkg::PERIOD_STOPPED);
      end else if (pick < 70) begin
        value = sealed({pfield[gdec_pkg::PFIELD_W-1 -: gdec_pkg::EXP_W], 9'd0});
      end else if (pick < 85) begin
        slot  = $urandom_range(0, 3);
        value = sealed(pfield) ^
                (16'(4'($urandom_range(1, 15))) << (slot * gdec_pkg::NIB_W));
      end else begin
        value = '0;
      end
      word = (pick < 85) ? gcr_encode(value) : gdec_pkg::WORD_W'($urandom);
      send_word(word);
    end
    s_tvalid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d telemetry words; %0d results checked, %0d flagged as errors,",
             sent, checked, flagged);
    $display("%0d reported a stopped motor, the rest carried a nonzero eRPM.", stopped);
    if (fails == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gdec_pkg.sv
sv/gdec_divider.sv
sv/gcr_erpm_telemetry_decoder.sv
sim/gcr_erpm_check.sv
sim/gcr_erpm_telemetry_decoder_tb.sv
